// File: sv/tiled_texture_span_walker_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tiled texture span walker
// Define NO_ASSERTIONS to compile every check to nothing.
// ----------------------------------------------------------------------------
`ifndef TILED_TEXTURE_SPAN_WALKER_DEFINES_SVH
`define TILED_TEXTURE_SPAN_WALKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition must never hold outside reset
`define TTSW_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define TTSW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define TTSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TTSW_ASSERT_NEVER(label, clk, rst, cond, msg)
`define TTSW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define TTSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/ttsw_pkg.sv
// ----------------------------------------------------------------------------
// ttsw_pkg
// Shared types and constants of the tiled texture span walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttsw_pkg;

  localparam int TEXTURE_WIDTH  = 256;
  localparam int SUBSPAN_LENGTH = 32;
  localparam int COUNT_W        = 6;
  localparam int ADDR_W         = 16;
  localparam int STORE_DEPTH    = 1 << ADDR_W;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] LFSR_TAPS   = 32'hA300_0000;
  localparam logic [31:0] JITTER_MASK = 32'h00FF_00FF;
  localparam logic [31:0] LFSR_RESET  = 32'h0000_0001;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SPAN  = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  // Input item
  typedef struct packed {
    logic               op;
    logic [15:0]        texel_address;
    logic [7:0]         texel_value;
    logic [31:0]        u_start;
    logic [31:0]        v_start;
    logic signed [31:0] u_step;
    logic signed [31:0] v_step;
    logic [5:0]         pixel_count;
  } in_t;

  // Result item
  typedef struct packed {
    logic [7:0] pixel;
    logic       last;
  } out_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t                kind;
    logic [ADDR_W-1:0]  addr;
    logic [7:0]         value;
    logic [31:0]        uv;
    logic [31:0]        duv;
    logic [COUNT_W-1:0] count;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/ttsw_queue.sv
// ----------------------------------------------------------------------------
// ttsw_queue
// Small command FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tiled_texture_span_walker_defines.svh"

module ttsw_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  ttsw_pkg::cmd_t     push_cmd,
  output logic               full,
  input  wire logic          pop,
  output ttsw_pkg::cmd_t     head,
  output logic               empty
);
  import ttsw_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TTSW_ASSERT_NEVER(a_no_overflow, clk, rst, push && full, "queue push while full")
  `TTSW_ASSERT_NEVER(a_no_underflow, clk, rst, pop && empty, "queue pop while empty")
  `TTSW_ASSERT_NEVER(a_count_bound, clk, rst, count > (QPTR_W+1)'(QUEUE_DEPTH),
                     "queue count out of range")

endmodule

`default_nettype wire

// File: sv/ttsw_front.sv
// ----------------------------------------------------------------------------
// ttsw_front
// Accepts input items, packs span coordinates and clamps the pixel count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttsw_front (
  input  wire logic       in_valid,
  output logic            in_ready,
  input  ttsw_pkg::in_t   in_data,
  output logic            push,
  output ttsw_pkg::cmd_t  push_cmd,
  input  wire logic       full
);
  import ttsw_pkg::*;

  logic               is_span;
  logic [COUNT_W-1:0] count_clamped;

  assign in_ready = !full;
  assign is_span  = (in_data.op == OP_SPAN);

  // Clamp the pixel count to the subspan length
  always_comb begin
    if (in_data.pixel_count > COUNT_W'(SUBSPAN_LENGTH)) begin
      count_clamped = COUNT_W'(SUBSPAN_LENGTH);
    end else begin
      count_clamped = in_data.pixel_count;
    end
  end

  // Build the command; pack u and v as [u 8.8 | v 8.8]
  always_comb begin
    push_cmd.kind  = is_span ? OP_SPAN : OP_WRITE;
    push_cmd.addr  = in_data.texel_address;
    push_cmd.value = in_data.texel_value;
    push_cmd.uv    = {in_data.u_start[23:8], in_data.v_start[23:8]};
    push_cmd.duv   = {in_data.u_step[23:8], in_data.v_step[23:8]};
    push_cmd.count = count_clamped;
  end

  // Drop empty spans at the door
  assign push = in_valid && !full && !(is_span && (count_clamped == '0));

endmodule

`default_nettype wire

// File: sv/ttsw_back.sv
// ----------------------------------------------------------------------------
// ttsw_back
// Executes commands: texel writes and span walks over the texture memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tiled_texture_span_walker_defines.svh"

module ttsw_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       dither_enable,
  input  ttsw_pkg::cmd_t  head,
  input  wire logic       empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ttsw_pkg::out_t  out_data
);
  import ttsw_pkg::*;

  logic [7:0]         texture_mem [STORE_DEPTH];

  state_t             state;
  state_t             state_next;
  logic [31:0]        uv;
  logic [31:0]        duv;
  logic [COUNT_W-1:0] remain;
  logic [31:0]        lfsr;
  logic [31:0]        lfsr_step;
  logic [31:0]        fetch_at;
  logic [ADDR_W-1:0]  rd_addr;

  logic               issue;
  logic               mem_we;
  logic               load_span;
  logic               rd_valid;
  logic               rd_last;
  logic [7:0]         rd_pixel;

  out_t               buf_q [2];
  logic               buf_wr;
  logic               buf_rd;
  logic [1:0]         buf_count;
  logic [1:0]         occupancy;
  logic               out_xfer;

  // Next LFSR value and dithered fetch coordinate
  assign lfsr_step = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? LFSR_TAPS : 32'h0);
  assign fetch_at  = dither_enable ? ((lfsr_step & JITTER_MASK) + uv) : uv;
  assign rd_addr   = {fetch_at[15:8], fetch_at[31:24]};

  // Output buffer handshake
  assign out_valid = (buf_count != 2'd0);
  assign out_data  = buf_q[buf_rd];
  assign out_xfer  = out_valid && out_ready;
  assign occupancy = buf_count + {1'b0, rd_valid} - {1'b0, out_xfer};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!empty && head.kind == OP_SPAN) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (issue && remain == COUNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    load_span = 1'b0;
    issue     = 1'b0;
    case (state)
      ST_IDLE: begin
        pop       = !empty;
        mem_we    = !empty && head.kind == OP_WRITE;
        load_span = !empty && head.kind == OP_SPAN;
      end
      ST_WALK: begin
        issue = (occupancy < 2'd2);
      end
      default: ;
    endcase
  end

  // Texture memory: write port and registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      texture_mem[head.addr] <= head.value;
    end
    if (issue) begin
      rd_pixel <= texture_mem[rd_addr];
    end
  end

  // Hold span coordinates; advance by the packed step per pixel
  always_ff @(posedge clk) begin
    if (load_span) begin
      uv     <= head.uv;
      duv    <= head.duv;
      remain <= head.count;
    end else if (issue) begin
      uv     <= uv + duv;
      remain <= remain - 1'b1;
    end
    if (issue) begin
      rd_last <= (remain == COUNT_W'(1));
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      lfsr     <= LFSR_RESET;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
      if (issue && dither_enable) begin
        lfsr <= lfsr_step;
      end
    end
  end

  // Capture fetched texels into the output buffer
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      buf_q[buf_wr] <= '{pixel: rd_pixel, last: rd_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_wr    <= 1'b0;
      buf_rd    <= 1'b0;
      buf_count <= 2'd0;
    end else begin
      if (rd_valid) begin
        buf_wr <= !buf_wr;
      end
      if (out_xfer) begin
        buf_rd <= !buf_rd;
      end
      buf_count <= buf_count + {1'b0, rd_valid} - {1'b0, out_xfer};
    end
  end

  `TTSW_ASSERT_NEVER(a_buf_bound, clk, rst, buf_count > 2'd2, "output buffer overrun")
  `TTSW_ASSERT_IMPLY(a_issue_walk, clk, rst, issue, state == ST_WALK && remain != '0,
                     "fetch issued outside a span")
  `TTSW_ASSERT_NEXT(a_last_ends, clk, rst, issue && remain == COUNT_W'(1),
                    state == ST_IDLE && rd_valid && rd_last, "last pixel did not end span")

endmodule

`default_nettype wire

// File: sv/tiled_texture_span_walker.sv
// ----------------------------------------------------------------------------
// tiled_texture_span_walker
// Byte texture store with a linear (affine) span walker.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes texel writes (op = 0) and
//   subspans (op = 1). A texel write stores one byte and gives no result. A
//   subspan gives pixel_count results on the output channel (count clamped
//   to 32, zero count gives none), the final one with last set.
//   Output channel (out_valid/out_ready/out_data) carries one texel a
//   transfer. cfg_write/cfg_data set dither_enable; the user is to write
//   it only while the block is idle, which the block does not enforce.
//   With the queue empty, the first pixel of a subspan reaches out_valid
//   through the queue, the walk state, the registered read and the buffer.
//   The back end runs a texel write in its idle state and a subspan in its
//   walk state; the single texture read port fetches one texel per cycle
//   when the buffer has room, and a 4-entry queue keeps taking input items.
// Reset clears the queue, the walker, the output buffer and the LFSR (to 1);
// texture contents are undefined until written. When the receiver stalls,
// the two-entry output buffer fills and the walker holds its position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tiled_texture_span_walker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  ttsw_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output ttsw_pkg::out_t  out_data,
  input  wire logic       cfg_write,
  input  wire logic       cfg_data
);
  import ttsw_pkg::*;

  logic dither_enable;
  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  cmd_t head;
  logic empty;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      dither_enable <= 1'b0;
    end else if (cfg_write) begin
      dither_enable <= cfg_data;
    end
  end

  ttsw_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  ttsw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  ttsw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .dither_enable (dither_enable),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire
